@@ rtl/mcld_pkg.sv @@
// Shared types and constants for the motor command line decoder.
package mcld_pkg;

    localparam int SPEED_LIMIT = 9999;
    localparam int SPEED_W = 15;
    localparam int USPEED_W = 14;
    localparam int IDLE_W = 17;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [IDLE_W-1:0] IDLE_MAX = {IDLE_W{1'b1}};

    localparam logic [15:0] TIMEOUT_RESET = 16'd10000;
    localparam logic [7:0]  NEUTRAL_RESET = 8'd90;

    localparam logic [7:0] CH_L       = 8'h4C;
    localparam logic [7:0] CH_R       = 8'h52;
    localparam logic [7:0] CH_A       = 8'h41;
    localparam logic [7:0] CH_D       = 8'h64;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_VTAB    = 8'h0B;
    localparam logic [7:0] CH_FFEED   = 8'h0C;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [1:0] CAUSE_LINE    = 2'd0;
    localparam logic [1:0] CAUSE_DISARM  = 2'd1;
    localparam logic [1:0] CAUSE_TIMEOUT = 2'd2;
    localparam logic [1:0] CAUSE_UNUSED  = 2'd3;

    typedef enum logic [1:0] {
        FIELD_NONE = 2'd0,
        FIELD_L    = 2'd1,
        FIELD_R    = 2'd2,
        FIELD_A    = 2'd3
    } field_t;

    typedef enum logic {
        REG_LINK_TIMEOUT = 1'b0,
        REG_NEUTRAL_SPEED = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] speed_left;
        logic [USPEED_W-1:0]       speed_right;
        logic [USPEED_W-1:0]       speed_aux;
        logic [1:0]                cause;
    } out_item_t;

    typedef struct packed {
        logic [15:0] link_timeout_ticks;
        logic [7:0]  neutral_speed;
    } cfg_t;

endpackage

@@ rtl/mcld_cfg.sv @@
// APB register file holding the link timeout and the neutral speed.
module mcld_cfg
    import mcld_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t reg_index;
    logic       write_en;

    assign pready    = 1'b1;
    assign reg_index = reg_index_t'(paddr[2]);
    assign write_en  = psel && penable && pwrite;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (write_en)
        begin
            unique case (reg_index)
                REG_LINK_TIMEOUT:  cfg_next.link_timeout_ticks = pwdata[15:0];
                REG_NEUTRAL_SPEED: cfg_next.neutral_speed = pwdata[7:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index)
            REG_LINK_TIMEOUT:  prdata = {16'd0, cfg_reg.link_timeout_ticks};
            REG_NEUTRAL_SPEED: prdata = {24'd0, cfg_reg.neutral_speed};
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.link_timeout_ticks <= TIMEOUT_RESET;
            cfg_reg.neutral_speed <= NEUTRAL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/mcld_core.sv @@
// Per-item line parser, speed stores and link timeout counter.
module mcld_core
    import mcld_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  in_item_t  item,
    input  cfg_t      cfg,
    output logic      res_valid,
    output out_item_t res_item
);

    localparam int ACC_W = $clog2(SPEED_LIMIT + 1);
    localparam logic [ACC_W+3:0] LIMIT_WIDE = (ACC_W + 4)'(SPEED_LIMIT);
    localparam logic [ACC_W-1:0] LIMIT_ACC = ACC_W'(SPEED_LIMIT);

    logic signed [SPEED_W-1:0] left_reg, left_next, left_close;
    logic [USPEED_W-1:0]       right_reg, right_next, right_close;
    logic [USPEED_W-1:0]       aux_reg, aux_next, aux_close;
    logic [2:0]                seen_reg, seen_next;
    field_t                    field_reg, field_next;
    logic                      phase_reg, phase_next;
    logic                      neg_reg, neg_next;
    logic [ACC_W-1:0]          acc_reg, acc_next, acc_digit;
    logic [1:0]                len_reg, len_next;
    logic                      first_d_reg, first_d_next;
    logic [IDLE_W-1:0]         idle_reg, idle_next, idle_inc;
    logic                      timed_out_reg, timed_out_next;

    logic [7:0]                ch;
    logic                      is_digit;
    logic                      is_space;
    logic                      is_letter;
    field_t                    letter_field;
    logic [2:0]                letter_bit;
    logic [ACC_W+3:0]          acc_sum;
    logic signed [SPEED_W-1:0] acc_signed;
    logic [SPEED_W-1:0]        neutral_s;
    logic [USPEED_W-1:0]       neutral_u;

    assign ch        = item.rx_byte;
    assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign is_space  = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_VTAB)
                       || (ch == CH_FFEED) || (ch == CH_CR);
    assign is_letter = (ch == CH_L) || (ch == CH_R) || (ch == CH_A);
    assign neutral_s = {{(SPEED_W-8){1'b0}}, cfg.neutral_speed};
    assign neutral_u = {{(USPEED_W-8){1'b0}}, cfg.neutral_speed};

    always_comb
    begin
        unique case (ch)
            CH_L:    letter_field = FIELD_L;
            CH_R:    letter_field = FIELD_R;
            default: letter_field = FIELD_A;
        endcase
    end

    always_comb
    begin
        unique case (letter_field)
            FIELD_L: letter_bit = 3'b001;
            FIELD_R: letter_bit = 3'b010;
            FIELD_A: letter_bit = 3'b100;
            default: letter_bit = 3'b000;
        endcase
    end

    // Decimal shift-in of the next digit, saturating at the speed limit.
    assign acc_sum   = {acc_reg, 3'b000} + {2'b00, acc_reg, 1'b0}
                       + {{ACC_W{1'b0}}, ch[3:0]};
    assign acc_digit = (acc_sum > LIMIT_WIDE) ? LIMIT_ACC : acc_sum[ACC_W-1:0];

    assign acc_signed = neg_reg ? -SPEED_W'(acc_reg) : SPEED_W'(acc_reg);

    // Store values as they stand once the open field is closed.
    always_comb
    begin
        left_close  = left_reg;
        right_close = right_reg;
        aux_close   = aux_reg;
        case (field_reg)
            FIELD_L: left_close = acc_signed;
            FIELD_R: right_close = USPEED_W'(acc_reg);
            FIELD_A: aux_close = USPEED_W'(acc_reg);
            default: ;
        endcase
    end

    assign idle_inc = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + 1'b1;

    always_comb
    begin
        left_next      = left_reg;
        right_next     = right_reg;
        aux_next       = aux_reg;
        seen_next      = seen_reg;
        field_next     = field_reg;
        phase_next     = phase_reg;
        neg_next       = neg_reg;
        acc_next       = acc_reg;
        len_next       = len_reg;
        first_d_next   = first_d_reg;
        idle_next      = idle_reg;
        timed_out_next = timed_out_reg;
        res_valid      = 1'b0;
        res_item       = '0;

        if (accept)
        begin
            if (item.kind == KIND_TICK)
            begin
                idle_next = idle_inc;
                if ((idle_inc > {1'b0, cfg.link_timeout_ticks}) && !timed_out_reg)
                begin
                    timed_out_next       = 1'b1;
                    res_valid            = 1'b1;
                    res_item.speed_left  = neutral_s;
                    res_item.speed_right = neutral_u;
                    res_item.speed_aux   = neutral_u;
                    res_item.cause       = CAUSE_TIMEOUT;
                end
            end
            else
            begin
                idle_next      = '0;
                timed_out_next = 1'b0;
                if (ch == CH_NEWLINE)
                begin
                    res_valid = 1'b1;
                    if ((len_reg == 2'd1) && first_d_reg)
                    begin
                        left_next      = neutral_s;
                        right_next     = neutral_u;
                        aux_next       = neutral_u;
                        res_item.cause = CAUSE_DISARM;
                    end
                    else
                    begin
                        left_next      = left_close;
                        right_next     = right_close;
                        aux_next       = aux_close;
                        res_item.cause = CAUSE_LINE;
                    end
                    res_item.speed_left  = left_next;
                    res_item.speed_right = right_next;
                    res_item.speed_aux   = aux_next;
                    seen_next    = '0;
                    field_next   = FIELD_NONE;
                    phase_next   = 1'b0;
                    neg_next     = 1'b0;
                    acc_next     = '0;
                    len_next     = '0;
                    first_d_next = 1'b0;
                end
                else
                begin
                    if (len_reg == 2'd0)
                    begin
                        first_d_next = (ch == CH_D);
                    end
                    if (len_reg != 2'd2)
                    begin
                        len_next = len_reg + 1'b1;
                    end

                    if (is_letter)
                    begin
                        left_next  = left_close;
                        right_next = right_close;
                        aux_next   = aux_close;
                        field_next = FIELD_NONE;
                        if ((seen_reg & letter_bit) == 3'b000)
                        begin
                            seen_next  = seen_reg | letter_bit;
                            field_next = letter_field;
                            acc_next   = '0;
                            phase_next = 1'b0;
                            neg_next   = 1'b0;
                        end
                    end
                    else if (field_reg == FIELD_L && !phase_reg && is_space)
                    begin
                        // Leading white space before the sign is skipped.
                    end
                    else if (field_reg == FIELD_L && !phase_reg && ch == CH_PLUS)
                    begin
                        phase_next = 1'b1;
                    end
                    else if (field_reg == FIELD_L && !phase_reg && ch == CH_MINUS)
                    begin
                        phase_next = 1'b1;
                        neg_next   = 1'b1;
                    end
                    else if (field_reg != FIELD_NONE && is_digit)
                    begin
                        phase_next = 1'b1;
                        acc_next   = acc_digit;
                    end
                    else if (field_reg != FIELD_NONE)
                    begin
                        left_next  = left_close;
                        right_next = right_close;
                        aux_next   = aux_close;
                        field_next = FIELD_NONE;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg      <= '0;
            right_reg     <= '0;
            aux_reg       <= '0;
            seen_reg      <= '0;
            field_reg     <= FIELD_NONE;
            phase_reg     <= 1'b0;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            len_reg       <= '0;
            first_d_reg   <= 1'b0;
            idle_reg      <= '0;
            timed_out_reg <= 1'b0;
        end
        else
        begin
            left_reg      <= left_next;
            right_reg     <= right_next;
            aux_reg       <= aux_next;
            seen_reg      <= seen_next;
            field_reg     <= field_next;
            phase_reg     <= phase_next;
            neg_reg       <= neg_next;
            acc_reg       <= acc_next;
            len_reg       <= len_next;
            first_d_reg   <= first_d_next;
            idle_reg      <= idle_next;
            timed_out_reg <= timed_out_next;
        end
    end

endmodule

@@ rtl/mcld_obuf.sv @@
// Two-entry result buffer: an output register backed by one skid register.
module mcld_obuf
    import mcld_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  out_item_t push_item,
    output logic      full,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic      out_valid_reg, out_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_item_t out_item_reg, out_item_next;
    out_item_t skid_item_reg, skid_item_next;

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_item_next   = out_item_reg;
        skid_valid_next = skid_valid_reg;
        skid_item_next  = skid_item_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_item_next   = skid_item_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_item_next  = push_item;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_item_next  = push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg  <= out_item_next;
        skid_item_reg <= skid_item_next;
    end

endmodule

@@ rtl/motor_command_line_decoder.sv @@
// Top level of the motor command line decoder.
// The block takes one item per clock cycle while in_ready is high, either a
// received byte or a time tick, and turns newline-ended lines such as
// L-120R40A7 into three stored motor speeds; each newline yields one result
// with all three speeds, a line of just "d" sets all three to the neutral
// speed, and a run of ticks longer than link_timeout_ticks yields one neutral
// result. Each item is parsed in the cycle it is accepted; its result, if any,
// is registered into the output register, or into the skid register behind
// it while one result waits, which keeps input accepted; in_ready drops only
// when two results are pending. Registers: link_timeout_ticks at byte address
// 0 and neutral_speed at byte address 4, both readable.
module motor_command_line_decoder
    import mcld_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  in_item_t           in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output out_item_t          out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    cfg_t      cfg;
    logic      accept;
    logic      buf_full;
    logic      res_valid;
    out_item_t res_item;

    assign in_ready = !buf_full;
    assign accept   = in_valid && in_ready;

    mcld_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mcld_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (in_item),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

    mcld_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_item (res_item),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

@@ rtl/mcld_checker.sv @@
// Port-level checks for the motor command line decoder and their binding.
module mcld_checker
    import mcld_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_item
);

    // A stalled result item holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed while stalled");

    // Input is refused only while a result is waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

    // Disarm and timeout items carry the same speed on all three motors.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.cause == CAUSE_DISARM || out_item.cause == CAUSE_TIMEOUT)
        |-> out_item.speed_right == out_item.speed_aux
            && out_item.speed_left[USPEED_W-1:0] == out_item.speed_right
            && !out_item.speed_left[SPEED_W-1])
    else $error("neutral item with unequal speeds");

    // The cause field never carries the unused code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.cause != CAUSE_UNUSED)
    else $error("result item with unused cause");

endmodule

bind motor_command_line_decoder mcld_checker u_mcld_checker (.*);
